// ----- rtl/vn_pkg.sv -----
`timescale 1ns / 1ps
// Package for the 3D vector normalizer: widths, constants and the
// per-item pipeline record shared by all stages. No dependencies.
package vn_pkg;

    localparam int unsigned COMP_W    = 16;                // input component width
    localparam int unsigned MAG_W     = COMP_W + 1;        // magnitude, 0 to 32768
    localparam int unsigned SQ_W      = 31;                // square, at most 2^30
    localparam int unsigned LEN_W     = 32;                // sum of squares, at most 3 * 2^30
    localparam int unsigned FRAC_BITS = 14;                // Q1.14 output
    localparam int unsigned N_W       = FRAC_BITS + 1;     // result magnitude bits
    localparam int unsigned NUM_DIGITS = N_W;              // one stage per result bit
    localparam int unsigned T_W       = 50;                // running (2n - 1 + 2^k) * L
    localparam int unsigned REM_W     = 66;                // running remainder
    localparam int unsigned R_SHIFT   = 2 * FRAC_BITS + 2; // m^2 scale of the test
    localparam int unsigned DATA_W    = 3 * COMP_W;        // packed stream width

    // One component in flight through the digit stages.
    typedef struct packed {
        logic signed [REM_W-1:0] rem;
        logic signed [T_W-1:0]   t;
        logic [N_W-1:0]          n;
        logic                    neg;
    } lane_t;

    // One vector in flight through the digit stages.
    typedef struct packed {
        lane_t [2:0]      lane;
        logic [LEN_W-1:0] len;
        logic [LEN_W+1:0] len3;
        logic             zero;
    } item_t;

endpackage

// ----- rtl/vn_front.sv -----
`timescale 1ns / 1ps
// Front end of the normalizer: magnitudes, squares, squared length and
// the starting values for the digit stages. Uses vn_pkg.
module vn_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      ready,
    input  logic [vn_pkg::DATA_W-1:0] in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output vn_pkg::item_t             out_item
);
    import vn_pkg::*;

    logic             v1_reg, v2_reg, v3_reg, v4_reg;
    logic             rdy1, rdy2, rdy3, rdy4;

    logic [MAG_W-1:0] mag_next [3];
    logic [MAG_W-1:0] mag_reg  [3];
    logic [2:0]       neg_next;
    logic [2:0]       neg1_reg, neg2_reg, neg3_reg;
    logic [SQ_W-1:0]  sq_next  [3];
    logic [SQ_W-1:0]  sq2_reg  [3];
    logic [SQ_W-1:0]  sq3_reg  [3];
    logic [LEN_W-1:0] len_next;
    logic [LEN_W-1:0] len_reg;
    item_t            item_next;
    item_t            item_reg;

    // Each stage moves on when it is empty or the next one moves on.
    assign rdy4  = !v4_reg || out_ready;
    assign rdy3  = !v3_reg || rdy4;
    assign rdy2  = !v2_reg || rdy3;
    assign rdy1  = !v1_reg || rdy2;
    assign ready = rdy1;

    always_comb
    begin
        logic [MAG_W-1:0] ext;
        logic [2*MAG_W-1:0] prod;
        for (int i = 0; i < 3; i++)
        begin
            ext = {in_data[COMP_W*i + COMP_W-1], in_data[COMP_W*i +: COMP_W]};
            neg_next[i] = ext[MAG_W-1];
            mag_next[i] = ext[MAG_W-1] ? (~ext + MAG_W'(1)) : ext;
            prod = mag_reg[i] * mag_reg[i];
            sq_next[i] = prod[SQ_W-1:0];
        end
        len_next = LEN_W'(sq2_reg[0]) + LEN_W'(sq2_reg[1]) + LEN_W'(sq2_reg[2]);
    end

    // Starting point n = 0: the remainder is R - L with R = m^2 * 2^30, and
    // the running term for the top digit is (2^14 - 1) * L.
    always_comb
    begin
        item_next.len  = len_reg;
        item_next.len3 = (LEN_W+2)'(len_reg) + ((LEN_W+2)'(len_reg) << 1);
        item_next.zero = (len_reg == '0);
        for (int i = 0; i < 3; i++)
        begin
            item_next.lane[i].rem = $signed((REM_W'(sq3_reg[i]) << R_SHIFT)
                                            - REM_W'(len_reg));
            item_next.lane[i].t   = $signed((T_W'(len_reg) << FRAC_BITS)
                                            - T_W'(len_reg));
            item_next.lane[i].n   = '0;
            item_next.lane[i].neg = neg3_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            mag_reg  <= mag_next;
            neg1_reg <= neg_next;
        end
        if (rdy2 && v1_reg)
        begin
            sq2_reg  <= sq_next;
            neg2_reg <= neg1_reg;
        end
        if (rdy3 && v2_reg)
        begin
            sq3_reg  <= sq2_reg;
            neg3_reg <= neg2_reg;
            len_reg  <= len_next;
        end
        if (rdy4 && v3_reg)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_item  = item_reg;

endmodule

// ----- rtl/vn_digit.sv -----
`timescale 1ns / 1ps
// One digit stage of the normalizer: decides result bit DIGIT of all three
// components by a restoring trial subtract. Uses vn_pkg.
module vn_digit #(
    parameter int unsigned DIGIT = 0
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          ready,
    input  vn_pkg::item_t in_item,
    output logic          out_valid,
    input  logic          out_ready,
    output vn_pkg::item_t out_item
);
    import vn_pkg::*;

    logic                    valid_reg;
    item_t                   item_reg;
    item_t                   item_next;
    logic signed [REM_W-1:0] t_ext [3];
    logic signed [REM_W-1:0] diff  [3];
    logic [2:0]              take;
    logic [T_W-1:0]          step_up;
    logic [T_W-1:0]          step_dn;

    assign ready = !valid_reg || out_ready;

    // A taken bit adds 3L << (k-1) to the running term, a rejected one
    // takes L << (k-1) away, so the next stage sees its own trial term.
    assign step_up = (T_W'(in_item.len3) << DIGIT) >> 1;
    assign step_dn = (T_W'(in_item.len)  << DIGIT) >> 1;

    always_comb
    begin
        item_next = in_item;
        for (int i = 0; i < 3; i++)
        begin
            t_ext[i] = {{(REM_W-T_W){in_item.lane[i].t[T_W-1]}}, in_item.lane[i].t};
            diff[i]  = in_item.lane[i].rem - (t_ext[i] <<< (DIGIT + 2));
            take[i]  = !diff[i][REM_W-1];
            if (take[i])
            begin
                item_next.lane[i].rem      = diff[i];
                item_next.lane[i].n[DIGIT] = 1'b1;
                item_next.lane[i].t        = in_item.lane[i].t + $signed(step_up);
            end
            else
            begin
                item_next.lane[i].t        = in_item.lane[i].t - $signed(step_dn);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && in_valid)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// ----- rtl/vn_back.sv -----
`timescale 1ns / 1ps
// Output stage of the normalizer: restores the signs, forces the zero
// vector case and holds the result for the stream. Uses vn_pkg.
module vn_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      ready,
    input  vn_pkg::item_t             in_item,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [vn_pkg::DATA_W-1:0] out_data,
    output logic                      out_zero
);
    import vn_pkg::*;

    logic              valid_reg;
    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic              zero_reg;

    assign ready = !valid_reg || out_ready;

    always_comb
    begin
        logic [COMP_W-1:0] mag;
        for (int i = 0; i < 3; i++)
        begin
            mag = COMP_W'(in_item.lane[i].n);
            if (in_item.zero)
            begin
                data_next[COMP_W*i +: COMP_W] = '0;
            end
            else if (in_item.lane[i].neg)
            begin
                data_next[COMP_W*i +: COMP_W] = ~mag + COMP_W'(1);
            end
            else
            begin
                data_next[COMP_W*i +: COMP_W] = mag;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && in_valid)
        begin
            data_reg <= data_next;
            zero_reg <= in_item.zero;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_zero  = zero_reg;

endmodule

// ----- rtl/vec3_normalize.sv -----
`timescale 1ns / 1ps
// vec3_normalize: scales a signed 16-bit 3D vector to a Q1.14 unit vector.
// Throughput is one vector per cycle while m_tready is not held low; the
// 20-stage pipeline has one digit stage per result bit.
// Reset (rst_n, asynchronous, active low) clears only the stage valid bits;
// no data state is kept between vectors. Uses vn_pkg and the vn_* stages.
module vec3_normalize (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // comp_x [15:0], comp_y [31:16], comp_z [47:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // unit_x [15:0], unit_y [31:16], unit_z [47:32]
    output logic        m_tuser    // zero_length [0]
);
    import vn_pkg::*;

    // The pipeline has three parts. The front end takes four stages to form
    // the component magnitudes, their squares, the squared length L and the
    // starting values for the digit search. Then one stage per result bit,
    // from bit 14 down to bit 0, finds the largest n with
    // (2n - 1)^2 * L <= m^2 * 2^30, which is the component times 2^14 over
    // the length, rounded to nearest with ties away from zero. Each digit
    // stage keeps the remainder and a running term (2n - 1 + 2^k) * L, so a
    // trial costs one shifted subtract and no multiplier. The last stage
    // restores the signs, forces the zero case and holds the result for the master side.
    //
    // Every stage carries its own valid bit and loads whenever it is empty or
    // its successor moves on, so bubbles close up and a stalled result does
    // not stop new input transactions while empty stages remain.

    logic  stage_valid [NUM_DIGITS+1];
    logic  stage_ready [NUM_DIGITS+1];
    item_t stage_item  [NUM_DIGITS+1];

    vn_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .ready     (s_tready),
        .in_data   (s_tdata),
        .out_valid (stage_valid[0]),
        .out_ready (stage_ready[0]),
        .out_item  (stage_item[0])
    );

    // Digit stage j decides result bit NUM_DIGITS - 1 - j.
    for (genvar j = 0; j < NUM_DIGITS; j++)
    begin : g_digit
        vn_digit #(
            .DIGIT (NUM_DIGITS - 1 - j)
        ) u_digit (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stage_valid[j]),
            .ready     (stage_ready[j]),
            .in_item   (stage_item[j]),
            .out_valid (stage_valid[j+1]),
            .out_ready (stage_ready[j+1]),
            .out_item  (stage_item[j+1])
        );
    end

    vn_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (stage_valid[NUM_DIGITS]),
        .ready     (stage_ready[NUM_DIGITS]),
        .in_item   (stage_item[NUM_DIGITS]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_zero  (m_tuser)
    );

endmodule
